### sv/gregorian_date_difference_assert.svh
// assertion macros for the date difference block
`ifndef GREGORIAN_DATE_DIFFERENCE_ASSERT_SVH
`define GREGORIAN_DATE_DIFFERENCE_ASSERT_SVH

// property sampled on clock, off during reset
`define GDD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define GDD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/gdd_pkg.sv
package gdd_pkg;

   localparam int ACC_W = 28;

   typedef logic [ACC_W-1:0] acc_type;

   // one operation of the shared unit: acc = c +/- a * b
   typedef struct packed {
      logic        en;
      logic        sub;
      logic [23:0] a;
      logic [12:0] b;
      acc_type     c;
   } op_type;

   // x / 100 == (x * RECIP_100) >> RECIP_SHIFT for x below 43699
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;
   localparam logic [12:0] CENTURY     = 13'd100;
   localparam logic [12:0] DAYS_YEAR   = 13'd365;
   localparam logic [12:0] UNIT_ONE    = 13'd1;

   localparam logic [21:0] SPAN_MAX = 22'h3FFFFF;

   localparam logic [1:0] ORD_EQUAL   = 2'd0;
   localparam logic [1:0] ORD_LATER   = 2'd1;
   localparam logic [1:0] ORD_EARLIER = 2'd2;

   // days in the months before month m in a common year
   function automatic logic [8:0] days_before_month(input logic [3:0] m);
      logic [8:0] d;
      case (m)
         4'd0, 4'd1: d = 9'd0;
         4'd2:       d = 9'd31;
         4'd3:       d = 9'd59;
         4'd4:       d = 9'd90;
         4'd5:       d = 9'd120;
         4'd6:       d = 9'd151;
         4'd7:       d = 9'd181;
         4'd8:       d = 9'd212;
         4'd9:       d = 9'd243;
         4'd10:      d = 9'd273;
         4'd11:      d = 9'd304;
         4'd12:      d = 9'd334;
         default:    d = 9'd365;
      endcase
      return d;
   endfunction

endpackage

### sv/gregorian_date_difference.sv
// a sequencer runs 8 steps per date through one shared multiply-add unit,
// plus save, difference and abs steps, then loads the output register; a new
// item is accepted only once the last result is loaded and the sequencer is idle
// req_ready is high only while the sequencer is idle
// reset (synchronous, active high) returns the sequencer to idle and drops rsp_valid
module gregorian_date_difference (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [4:0]  req_day_a,
   input  logic [3:0]  req_month_a,
   input  logic [13:0] req_year_a,
   input  logic [4:0]  req_day_b,
   input  logic [3:0]  req_month_b,
   input  logic [13:0] req_year_b,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_order,
   output logic [21:0] rsp_day_span
);
   import gdd_pkg::*;

   `include "gregorian_date_difference_assert.svh"

   // sequencer steps
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_QY   = 4'd1;   // y * 1/100
   localparam logic [3:0] S_CY   = 4'd2;   // (y / 100) * 100
   localparam logic [3:0] S_QP   = 4'd3;   // leap flag, p * 1/100
   localparam logic [3:0] S_Q4   = 4'd4;   // (p / 4) * 1/100
   localparam logic [3:0] S_BASE = 4'd5;   // 365 * y + p / 4
   localparam logic [3:0] S_SUBQ = 4'd6;   // - p / 100
   localparam logic [3:0] S_ADDQ = 4'd7;   // + p / 400
   localparam logic [3:0] S_DOY  = 4'd8;   // + day of year + 1 (year zero: day of year only)
   localparam logic [3:0] S_SAVE = 4'd9;   // keep first ordinal
   localparam logic [3:0] S_DIFF = 4'd10;  // oa - ob
   localparam logic [3:0] S_ABS  = 4'd11;  // ob - oa when negative
   localparam logic [3:0] S_OUT  = 4'd12;  // load output register

   logic [3:0]  state_ff, state_in;
   logic        sel_ff, sel_in;      // 0 first date, 1 second date

   // captured item
   logic [4:0]  da_ff, db_ff;
   logic [3:0]  ma_ff, mb_ff;
   logic [13:0] ya_ff, yb_ff;
   logic [1:0]  ord_ff;

   // per-date scratch
   logic [7:0]  qy_ff, qp_ff, q4_ff;
   logic        leap_ff;
   logic [22:0] oa_ff, ob_ff;

   // output register
   logic        rsp_valid_ff;
   logic [1:0]  rsp_order_ff;
   logic [21:0] rsp_day_span_ff;

   op_type      unit_op;
   acc_type     acc;

   // date under work
   logic [4:0]  cur_d;
   logic [3:0]  cur_m;
   logic [13:0] cur_y;
   logic [13:0] cur_p;
   logic [7:0]  acc_q;
   logic        cent;
   logic [8:0]  doy;
   logic        out_free;
   logic [22:0] key_a, key_b;
   logic [21:0] span_sat;

   gdd_unit u_unit (
      .clock (clock),
      .op    (unit_op),
      .acc   (acc)
   );

   assign cur_d = sel_ff ? db_ff : da_ff;
   assign cur_m = sel_ff ? mb_ff : ma_ff;
   assign cur_y = sel_ff ? yb_ff : ya_ff;
   assign cur_p = cur_y - 14'd1;

   // quotient by 100 sits in the upper product bits
   assign acc_q = acc[RECIP_SHIFT+7:RECIP_SHIFT];

   // year is a whole century when 100 * (y / 100) gives back y
   assign cent = (acc == {{(ACC_W-14){1'b0}}, cur_y});

   // day of year plus the extra day of year zero; year zero itself adds nothing
   assign doy = days_before_month(cur_m) + {4'd0, cur_d}
              + {8'd0, (cur_m > 4'd2) && leap_ff}
              + {8'd0, cur_y != 14'd0};

   assign key_a = {req_year_a, req_month_a, req_day_a};
   assign key_b = {req_year_b, req_month_b, req_day_b};

   assign span_sat = (acc[ACC_W-1:22] != '0) ? SPAN_MAX : acc[21:0];

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   // operation for the shared unit in each step
   always_comb begin
      unit_op = '0;
      case (state_ff)
         S_QY: begin
            unit_op.en = 1'b1;
            unit_op.a  = {10'd0, cur_y};
            unit_op.b  = RECIP_100;
         end
         S_CY: begin
            unit_op.en = 1'b1;
            unit_op.a  = {16'd0, acc_q};
            unit_op.b  = CENTURY;
         end
         S_QP: begin
            unit_op.en = 1'b1;
            unit_op.a  = {10'd0, cur_p};
            unit_op.b  = RECIP_100;
         end
         S_Q4: begin
            unit_op.en = 1'b1;
            unit_op.a  = {12'd0, cur_p[13:2]};
            unit_op.b  = RECIP_100;
         end
         S_BASE: begin
            unit_op.en = 1'b1;
            unit_op.a  = {10'd0, cur_y};
            unit_op.b  = DAYS_YEAR;
            unit_op.c  = {{(ACC_W-12){1'b0}}, cur_p[13:2]};
         end
         S_SUBQ: begin
            unit_op.en  = 1'b1;
            unit_op.sub = 1'b1;
            unit_op.a   = {16'd0, qp_ff};
            unit_op.b   = UNIT_ONE;
            unit_op.c   = acc;
         end
         S_ADDQ: begin
            unit_op.en = 1'b1;
            unit_op.a  = {16'd0, q4_ff};
            unit_op.b  = UNIT_ONE;
            unit_op.c  = acc;
         end
         S_DOY: begin
            unit_op.en = 1'b1;
            unit_op.a  = {15'd0, doy};
            unit_op.b  = UNIT_ONE;
            unit_op.c  = (cur_y == 14'd0) ? '0 : acc;
         end
         S_DIFF: begin
            unit_op.en  = 1'b1;
            unit_op.sub = 1'b1;
            unit_op.a   = {1'b0, acc[22:0]};
            unit_op.b   = UNIT_ONE;
            unit_op.c   = {{(ACC_W-23){1'b0}}, oa_ff};
         end
         S_ABS: begin
            // a borrow means the second ordinal is the larger one
            unit_op.en  = acc[ACC_W-1];
            unit_op.sub = 1'b1;
            unit_op.a   = {1'b0, oa_ff};
            unit_op.b   = UNIT_ONE;
            unit_op.c   = {{(ACC_W-23){1'b0}}, ob_ff};
         end
         default: unit_op = '0;
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_QY;
               sel_in   = 1'b0;
            end
         end
         S_QY:   state_in = S_CY;
         S_CY:   state_in = S_QP;
         S_QP:   state_in = S_Q4;
         S_Q4:   state_in = S_BASE;
         S_BASE: state_in = S_SUBQ;
         S_SUBQ: state_in = S_ADDQ;
         S_ADDQ: state_in = S_DOY;
         S_DOY:  state_in = sel_ff ? S_DIFF : S_SAVE;
         S_SAVE: begin
            state_in = S_QY;
            sel_in   = 1'b1;
         end
         S_DIFF: state_in = S_ABS;
         S_ABS:  state_in = S_OUT;
         S_OUT: begin
            // wait here while the previous result is still not taken
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         if (state_ff == S_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload and scratch registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         da_ff <= req_day_a;
         ma_ff <= req_month_a;
         ya_ff <= req_year_a;
         db_ff <= req_day_b;
         mb_ff <= req_month_b;
         yb_ff <= req_year_b;
         // order follows the raw fields: year, then month, then day
         if (key_a > key_b) begin
            ord_ff <= ORD_LATER;
         end else if (key_a < key_b) begin
            ord_ff <= ORD_EARLIER;
         end else begin
            ord_ff <= ORD_EQUAL;
         end
      end
      if (state_ff == S_CY) begin
         qy_ff <= acc_q;
      end
      if (state_ff == S_QP) begin
         // 4/100/400 rule: a century is leap only when y / 100 is a multiple of 4
         leap_ff <= ((cur_y[1:0] == 2'b00) && !cent) || (cent && (qy_ff[1:0] == 2'b00));
      end
      if (state_ff == S_Q4) begin
         qp_ff <= acc_q;
      end
      if (state_ff == S_BASE) begin
         q4_ff <= acc_q;
      end
      if (state_ff == S_SAVE) begin
         oa_ff <= acc[22:0];
      end
      if (state_ff == S_DIFF) begin
         ob_ff <= acc[22:0];
      end
      if (state_ff == S_OUT && out_free) begin
         rsp_order_ff    <= ord_ff;
         rsp_day_span_ff <= span_sat;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_order    = rsp_order_ff;
   assign rsp_day_span = rsp_day_span_ff;

   // a transfer starts the first date's steps
   `GDD_ASSERT_NEXT(a_start, req_valid && req_ready, (state_ff == S_QY) && !sel_ff, "accepted item did not start the sequence")
   // equal dates give a zero span
   `GDD_ASSERT(a_equal_span, !(rsp_valid && (rsp_order == ORD_EQUAL)) || (rsp_day_span == 22'd0), "equal dates with nonzero span")
   // a finished result waits while the output register is occupied
   `GDD_ASSERT_NEXT(a_out_hold, (state_ff == S_OUT) && rsp_valid && !rsp_ready, state_ff == S_OUT, "result overwrote a pending transfer")

endmodule

### sv/gdd_unit.sv
module gdd_unit (
   input  logic            clock,
   input  gdd_pkg::op_type op,
   output gdd_pkg::acc_type acc
);
   import gdd_pkg::*;

   logic [36:0] prod;
   acc_type     acc_ff;
   acc_type     acc_in;

   // multiply then add or subtract, result held in the accumulator
   always_comb begin
      prod   = op.a * op.b;
      acc_in = op.sub ? (op.c - prod[ACC_W-1:0]) : (op.c + prod[ACC_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (op.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule
